>>> rtl/tt_pkg.sv
// ----------------------------------------------------------------------------
// tt_pkg
// Types, widths and helpers shared by the triangle tangent basis block.
// ----------------------------------------------------------------------------
package tt_pkg;

    localparam int POS_W  = 24;
    localparam int UV_W   = 20;
    localparam int DPOS_W = POS_W + 1;      // position difference
    localparam int DUV_W  = UV_W + 1;       // uv difference
    localparam int PROD_W = DPOS_W + DUV_W; // one product
    localparam int ACC_W  = 48;             // det and numerators
    localparam int MAG_W  = ACC_W - 1;      // magnitude of an accumulator
    localparam int OUT_W  = 32;

    // one vertex request
    typedef struct packed {
        logic signed [POS_W-1:0] position_x;
        logic signed [POS_W-1:0] position_y;
        logic signed [POS_W-1:0] position_z;
        logic signed [UV_W-1:0]  tex_u;
        logic signed [UV_W-1:0]  tex_v;
    } t_vertex;

    // one triangle result
    typedef struct packed {
        logic signed [OUT_W-1:0] tangent_x;
        logic signed [OUT_W-1:0] tangent_y;
        logic signed [OUT_W-1:0] tangent_z;
        logic signed [OUT_W-1:0] bitangent_x;
        logic signed [OUT_W-1:0] bitangent_y;
        logic signed [OUT_W-1:0] bitangent_z;
        logic                    degenerate;
        logic                    clipped;
    } t_result;

    // triangle as edge and uv deltas, handed from front to back
    typedef struct packed {
        logic [2:0][DPOS_W-1:0] ab;
        logic [2:0][DPOS_W-1:0] ac;
        logic [DUV_W-1:0]       du1;
        logic [DUV_W-1:0]       dv1;
        logic [DUV_W-1:0]       du2;
        logic [DUV_W-1:0]       dv2;
    } t_tri;

    function automatic logic [DPOS_W-1:0] pos_diff(logic [POS_W-1:0] hi, logic [POS_W-1:0] lo);
        pos_diff = {hi[POS_W-1], hi} - {lo[POS_W-1], lo};
    endfunction

    function automatic logic [DUV_W-1:0] uv_diff(logic [UV_W-1:0] hi, logic [UV_W-1:0] lo);
        uv_diff = {hi[UV_W-1], hi} - {lo[UV_W-1], lo};
    endfunction

endpackage

>>> rtl/tt_front.sv
// ----------------------------------------------------------------------------
// tt_front
// Counts corners, holds the first two and pushes edge/uv deltas per triangle while enabled.
// ----------------------------------------------------------------------------
module tt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tt_pkg::t_vertex i_vtx,
    input  logic            i_enable,
    output logic            o_push,
    output tt_pkg::t_tri    o_tri,
    input  logic            i_full
);
    import tt_pkg::*;

    logic [1:0] r_count;
    t_vertex    r_a;
    t_vertex    r_b;
    logic       w_accept;
    logic       w_last;

    assign w_last   = (r_count == 2'd2);
    assign o_ready  = !(w_last && i_enable && i_full);
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && w_last && i_enable;

    // deltas against corner a
    always_comb begin
        o_tri.ab[0] = pos_diff(r_b.position_x, r_a.position_x);
        o_tri.ab[1] = pos_diff(r_b.position_y, r_a.position_y);
        o_tri.ab[2] = pos_diff(r_b.position_z, r_a.position_z);
        o_tri.ac[0] = pos_diff(i_vtx.position_x, r_a.position_x);
        o_tri.ac[1] = pos_diff(i_vtx.position_y, r_a.position_y);
        o_tri.ac[2] = pos_diff(i_vtx.position_z, r_a.position_z);
        o_tri.du1   = uv_diff(r_b.tex_u, r_a.tex_u);
        o_tri.dv1   = uv_diff(r_b.tex_v, r_a.tex_v);
        o_tri.du2   = uv_diff(i_vtx.tex_u, r_a.tex_u);
        o_tri.dv2   = uv_diff(i_vtx.tex_v, r_a.tex_v);
    end

    // corner counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (w_accept) begin
            r_count <= w_last ? 2'd0 : r_count + 2'd1;
        end
    end

    // held corners
    always_ff @(posedge i_clk) begin
        if (w_accept && r_count == 2'd0) begin
            r_a <= i_vtx;
        end
        if (w_accept && r_count == 2'd1) begin
            r_b <= i_vtx;
        end
    end

endmodule

>>> rtl/tt_queue.sv
// ----------------------------------------------------------------------------
// tt_queue
// Two-entry queue of triangles between front and back.
// ----------------------------------------------------------------------------
module tt_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  tt_pkg::t_tri i_tri,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output tt_pkg::t_tri o_tri
);
    import tt_pkg::*;

    t_tri       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_tri   = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_tri;
        end
    end

endmodule

>>> rtl/tt_back.sv
// ----------------------------------------------------------------------------
// tt_back
// Sequenced multiply-accumulate for det and numerators, then, unless det
// is zero, a shared restoring divider for the six Q16.16 quotients.
// ----------------------------------------------------------------------------
module tt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  tt_pkg::t_tri    i_tri,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output tt_pkg::t_result o_res
);
    import tt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_DSET = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    localparam logic [3:0] LAST_K = 4'd14;

    t_state                    r_state;
    t_tri                      r_op;
    logic [3:0]                r_k;
    logic                      r_pv;
    logic [3:0]                r_ptag;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   r_num [7];
    logic [2:0]                r_c;
    logic [MAG_W-1:0]          r_n;
    logic [MAG_W-1:0]          r_d;
    logic [MAG_W-1:0]          r_rem;
    logic [OUT_W-1:0]          r_q;
    logic [4:0]                r_cnt;
    logic                      r_neg;
    logic                      r_ovf;
    logic [OUT_W-1:0]          r_res [6];
    logic                      r_clip;
    logic                      r_degen;

    logic signed [DPOS_W-1:0]  w_mx;
    logic signed [DUV_W-1:0]   w_my;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]   w_pext;
    logic signed [ACC_W-1:0]   w_num;
    logic [MAG_W-1:0]          w_nmag;
    logic [ACC_W-1:0]          w_nneg;
    logic [ACC_W-1:0]          w_dneg;
    logic [MAG_W:0]            w_trial;
    logic                      w_qbit;
    logic [OUT_W:0]            w_lim;
    logic                      w_sat;
    logic [OUT_W-1:0]          w_val;
    logic [2:0]                w_idx;

    // operand select for the shared multiplier
    always_comb begin
        w_mx = '0;
        w_my = '0;
        case (r_k[3:1]) inside
            3'd0: begin
                w_mx = r_k[0] ? $signed({{4{r_op.du2[DUV_W-1]}}, r_op.du2})
                              : $signed({{4{r_op.du1[DUV_W-1]}}, r_op.du1});
                w_my = r_k[0] ? $signed(r_op.dv1) : $signed(r_op.dv2);
            end
            [3'd1:3'd3]: begin
                w_mx = r_k[0] ? $signed(r_op.ac[2'(r_k[3:1] - 3'd1)])
                              : $signed(r_op.ab[2'(r_k[3:1] - 3'd1)]);
                w_my = r_k[0] ? $signed(r_op.dv1) : $signed(r_op.dv2);
            end
            [3'd4:3'd6]: begin
                w_mx = r_k[0] ? $signed(r_op.ab[2'(r_k[3:1] - 3'd4)])
                              : $signed(r_op.ac[2'(r_k[3:1] - 3'd4)]);
                w_my = r_k[0] ? $signed(r_op.du2) : $signed(r_op.du1);
            end
            default: begin
                w_mx = '0;
                w_my = '0;
            end
        endcase
    end

    assign w_prod = w_mx * w_my;
    assign w_pext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // numerator magnitude for the current component
    assign w_idx  = r_c + 3'd1;
    assign w_num  = r_num[w_idx];
    assign w_nneg = '0 - w_num;
    assign w_nmag = w_num[ACC_W-1] ? w_nneg[MAG_W-1:0] : w_num[MAG_W-1:0];
    assign w_dneg = '0 - r_num[0];

    // one restoring step
    assign w_qbit  = r_cnt[4] ? r_n[r_cnt[3:0]] : 1'b0;
    assign w_trial = {r_rem, w_qbit};

    // clamp and sign
    assign w_lim = r_neg ? 33'h080000000 : 33'h07FFFFFFF;
    assign w_sat = r_ovf || ({1'b0, r_q} > w_lim);
    assign w_val = w_sat ? w_lim[OUT_W-1:0] : r_q;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_pv <= (r_k != LAST_K);
                    if (r_k == LAST_K) begin
                        r_state <= (r_num[0] == '0) ? S_OUT : S_DSET;
                    end
                end
                S_DSET: begin
                    r_state <= ({16'b0, w_nmag} >= {r_d, 16'b0}) ? S_FIN : S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == 5'd0) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= (r_c == 3'd5) ? S_OUT : S_DSET;
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op    <= i_tri;
                r_k     <= 4'd0;
                r_c     <= 3'd0;
                r_clip  <= 1'b0;
                r_degen <= 1'b0;
            end
            S_MUL: begin
                if (r_k != LAST_K) begin
                    r_prod <= w_prod;
                    r_ptag <= r_k;
                    r_k    <= r_k + 4'd1;
                end else begin
                    r_d <= r_num[0][ACC_W-1] ? w_dneg[MAG_W-1:0] : r_num[0][MAG_W-1:0];
                    if (r_num[0] == '0) begin
                        r_degen <= 1'b1;
                        for (int i = 0; i < 6; i++) r_res[i] <= '0;
                    end
                end
            end
            S_DSET: begin
                r_n   <= w_nmag;
                r_neg <= w_num[ACC_W-1] ^ r_num[0][ACC_W-1];
                r_ovf <= ({16'b0, w_nmag} >= {r_d, 16'b0});
                r_rem <= {16'b0, w_nmag[MAG_W-1:16]};
                r_q   <= '0;
                r_cnt <= 5'd31;
            end
            S_DIV: begin
                if (w_trial >= {1'b0, r_d}) begin
                    r_rem <= MAG_W'(w_trial - {1'b0, r_d});
                    r_q   <= {r_q[OUT_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial[MAG_W-1:0];
                    r_q   <= {r_q[OUT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
            end
            S_FIN: begin
                r_res[r_c] <= r_neg ? (0 - w_val) : w_val;
                r_clip     <= r_clip | w_sat;
                r_c        <= r_c + 3'd1;
            end
            default: ;
        endcase
        // accumulate the product issued last cycle
        if (r_pv) begin
            if (!r_ptag[0]) r_acc <= w_pext;
            else            r_num[r_ptag[3:1]] <= r_acc - w_pext;
        end
    end

    assign o_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        o_res.tangent_x   = r_res[0];
        o_res.tangent_y   = r_res[1];
        o_res.tangent_z   = r_res[2];
        o_res.bitangent_x = r_res[3];
        o_res.bitangent_y = r_res[4];
        o_res.bitangent_z = r_res[5];
        o_res.degenerate  = r_degen;
        o_res.clipped     = r_clip;
    end

endmodule

>>> rtl/triangle_tangent_basis.sv
// ----------------------------------------------------------------------------
// triangle_tangent_basis
// Per-triangle tangent and bitangent from positions and UVs.
//
//   channel  dir  handshake            payload
//   vertex   in   i_valid / o_ready    i_vtx  (t_vertex)
//   result   out  o_valid / i_ready    o_res  (t_result)
//   config   in   i_cfg_we             i_cfg_data (basis_enable)
//
// Vertices are taken one per cycle; each third corner queues a triangle
// while basis_enable is set. The back end runs each triangle on the one
// shared multiplier, then per component on a one-bit-per-cycle divider.
// Input stalls only when the two-entry queue is full at a third corner.
// Synchronous active-low reset; basis_enable resets to 1.
// ----------------------------------------------------------------------------
module triangle_tangent_basis (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tt_pkg::t_vertex i_vtx,
    output logic            o_valid,
    input  logic            i_ready,
    output tt_pkg::t_result o_res,
    input  logic            i_cfg_we,
    input  logic            i_cfg_data
);
    import tt_pkg::*;

    logic r_enable;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_qv;
    t_tri w_tri_in;
    t_tri w_tri_out;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_data;
        end
    end

    tt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_vtx   (i_vtx),
        .i_enable(r_enable),
        .o_push  (w_push),
        .o_tri   (w_tri_in),
        .i_full  (w_full)
    );

    tt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_tri   (w_tri_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qv),
        .o_tri   (w_tri_out)
    );

    tt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_qv),
        .i_tri    (w_tri_out),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_res    (o_res)
    );

endmodule

>>> rtl/tt_checker.sv
// ----------------------------------------------------------------------------
// tt_checker
// Port-level checks on the triangle tangent basis block, bound to the top.
// ----------------------------------------------------------------------------
module tt_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_valid,
    input logic            i_ready,
    input tt_pkg::t_result o_res
);
    import tt_pkg::*;

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // degenerate triangle carries zero vectors and no clip
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.degenerate) |->
        (o_res.tangent_x == 0 && o_res.tangent_y == 0 && o_res.tangent_z == 0 &&
         o_res.bitangent_x == 0 && o_res.bitangent_y == 0 &&
         o_res.bitangent_z == 0 && !o_res.clipped))
        else $error("degenerate result not zero");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_res)))
        else $error("stalled result changed");

endmodule

bind triangle_tangent_basis tt_checker u_tt_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_res  (o_res)
);
